>>> rtl/core/gray_neighbor_difference_edge_detect_assert.svh
// Assertion macros used by the checker of the edge detector.
`ifndef GRAY_NEIGHBOR_DIFFERENCE_EDGE_DETECT_ASSERT_SVH
`define GRAY_NEIGHBOR_DIFFERENCE_EDGE_DETECT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define GND_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, switched off while reset is high.
`define GND_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that is also checked during reset.
`define GND_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> rtl/core/gnd_pkg.sv
`timescale 1ns / 1ps
package gnd_pkg;

  localparam int GND_MAX_WIDTH = 2048;

  localparam int PIX_W      = 8;
  localparam int GRAY_W     = 8;
  localparam int DIM_W      = 12;
  localparam int WVAL_W     = 14;
  localparam int OCOL_W     = 11;
  localparam int THR_W      = 8;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = 24;
  localparam int WIN_SIZE   = 9;
  localparam int CENTER     = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] WEIGHT_RED   = 16'd19661;
  localparam logic [15:0] WEIGHT_GREEN = 16'd38666;
  localparam logic [15:0] WEIGHT_BLUE  = 16'd7209;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd16;
  localparam logic [DIM_W-1:0] WIDTH_RESET     = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET    = 12'd480;

  typedef logic [GRAY_W-1:0] gray_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } dims_t;

  typedef struct packed {
    gray_t [WIN_SIZE-1:0] win;
    logic [DIM_W-1:0]     row;
    logic [OCOL_W-1:0]    col;
    logic                 last;
  } item_t;

endpackage

>>> rtl/core/gnd_front.sv
`timescale 1ns / 1ps
module gnd_front #(
  parameter int MAX_WIDTH = gnd_pkg::GND_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gnd_pkg::dims_t                dims,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gnd_pkg::PIX_W-1:0]     red,
  input  logic [gnd_pkg::PIX_W-1:0]     green,
  input  logic [gnd_pkg::PIX_W-1:0]     blue,
  input  logic [gnd_pkg::LEVEL_W-1:0]   level,
  output logic                          push,
  output gnd_pkg::item_t                item
);
  import gnd_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [WVAL_W-1:0] MAX_W_VAL = WVAL_W'(MAX_WIDTH);

  gray_t line_above [MAX_WIDTH];
  gray_t line_two_above [MAX_WIDTH];

  logic [DIM_W-1:0]  col;
  logic [DIM_W-1:0]  row;

  logic [WVAL_W-1:0] wid;
  logic [DIM_W-1:0]  hgt;
  logic [WVAL_W-1:0] col_eff;
  logic [WVAL_W-1:0] col_inc;
  logic [WVAL_W-1:0] col_dec;
  logic [DIM_W:0]    row_inc;
  logic              row_end;
  logic              col_end;
  logic [AW-1:0]     idx0;
  logic              prod0;
  logic              accept;
  logic [PROD_W-1:0] p_red;
  logic [PROD_W-1:0] p_green;
  logic [PROD_W-1:0] p_blue;

  logic              s1_valid;
  logic              s1_prod;
  logic [AW-1:0]     s1_idx;
  logic [PROD_W-1:0] s1_pr;
  logic [PROD_W-1:0] s1_pg;
  logic [PROD_W-1:0] s1_pb;
  logic [DIM_W-1:0]  s1_row;
  logic [OCOL_W-1:0] s1_col;
  logic              s1_last;
  logic              s1_fwd;
  gray_t             s1_fwd_up2;
  gray_t             s1_fwd_up1;
  gray_t             rd_above;
  gray_t             rd_two_above;

  logic [PROD_W-1:0] sum1;
  gray_t             gray1;
  gray_t             up2_eff;
  gray_t             up1_eff;
  gray_t [WIN_SIZE-1:0] win;
  gray_t [WIN_SIZE-1:0] win_next;

  always_comb begin
    wid = WVAL_W'(dims.image_width);
    if (wid > MAX_W_VAL) begin
      wid = MAX_W_VAL;
    end
    if (wid == '0) begin
      wid = WVAL_W'(1);
    end
    hgt = (dims.image_height == '0) ? DIM_W'(1) : dims.image_height;
    col_eff = (WVAL_W'(col) >= wid) ? wid - WVAL_W'(1) : WVAL_W'(col);
    col_inc = col_eff + WVAL_W'(1);
    col_dec = col_eff - WVAL_W'(1);
    row_inc = {1'b0, row} + (DIM_W + 1)'(1);
    row_end = row_inc >= {1'b0, hgt};
    col_end = col_inc >= wid;
    idx0    = col_eff[AW-1:0];
    prod0   = (row >= DIM_W'(2)) && (col_eff >= WVAL_W'(2));
    p_red   = PROD_W'(red) * PROD_W'(WEIGHT_RED);
    p_green = PROD_W'(green) * PROD_W'(WEIGHT_GREEN);
    p_blue  = PROD_W'(blue) * PROD_W'(WEIGHT_BLUE);
  end

  // Every item in stage one may still need a queue slot.
  assign in_ready = ((LEVEL_W + 1)'(level) + (LEVEL_W + 1)'(s1_valid & s1_prod))
                    < (LEVEL_W + 1)'(QUEUE_DEPTH);
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col <= col_inc[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod    <= prod0;
      s1_idx     <= idx0;
      s1_pr      <= p_red;
      s1_pg      <= p_green;
      s1_pb      <= p_blue;
      s1_row     <= row - DIM_W'(1);
      s1_col     <= col_dec[OCOL_W-1:0];
      s1_last    <= row_end && col_end;
      // The line store read misses a write to the same entry in this cycle.
      s1_fwd     <= s1_valid && (s1_idx == idx0);
      s1_fwd_up2 <= up1_eff;
      s1_fwd_up1 <= gray1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_above <= line_above[idx0];
    end
    if (s1_valid) begin
      line_above[s1_idx] <= gray1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_two_above <= line_two_above[idx0];
    end
    if (s1_valid) begin
      line_two_above[s1_idx] <= up1_eff;
    end
  end

  always_comb begin
    sum1    = s1_pr + s1_pg + s1_pb;
    gray1   = sum1[PROD_W-1 -: GRAY_W];
    up2_eff = s1_fwd ? s1_fwd_up2 : rd_two_above;
    up1_eff = s1_fwd ? s1_fwd_up1 : rd_above;
    win_next    = win;
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = up2_eff;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = up1_eff;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = gray1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  assign push      = s1_valid && s1_prod;
  assign item.win  = win_next;
  assign item.row  = s1_row;
  assign item.col  = s1_col;
  assign item.last = s1_last;

endmodule

>>> rtl/core/gnd_queue.sv
`timescale 1ns / 1ps
module gnd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  gnd_pkg::item_t              push_item,
  input  logic                        pop,
  output logic                        head_valid,
  output gnd_pkg::item_t              head,
  output logic [gnd_pkg::LEVEL_W-1:0] level
);
  import gnd_pkg::*;

  item_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + LEVEL_W'(1);
      end else if (pop && !push) begin
        level <= level - LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign head_valid = (level != '0);
  assign head       = entries[rd_ptr];

endmodule

>>> rtl/core/gnd_back.sv
`timescale 1ns / 1ps
module gnd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [gnd_pkg::THR_W-1:0]  threshold,
  input  logic                       head_valid,
  input  gnd_pkg::item_t             head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       edge_flag,
  output logic [gnd_pkg::DIM_W-1:0]  out_row,
  output logic [gnd_pkg::OCOL_W-1:0] out_col,
  output logic                       last_result
);
  import gnd_pkg::*;

  gray_t center;
  gray_t diff;
  logic  edge_found;

  always_comb begin
    center     = head.win[CENTER];
    edge_found = 1'b0;
    diff       = '0;
    for (int k = 0; k < WIN_SIZE; k++) begin
      diff = (head.win[k] > center) ? head.win[k] - center : center - head.win[k];
      if ((k != CENTER) && (diff > threshold)) begin
        edge_found = 1'b1;
      end
    end
  end

  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      edge_flag   <= edge_found;
      out_row     <= head.row;
      out_col     <= head.col;
      last_result <= head.last;
    end
  end

endmodule

>>> rtl/core/gray_neighbor_difference_edge_detect.sv
`timescale 1ns / 1ps
// A result passes the stage-one registers, the queue and the output register.
// Throughput: one pixel per cycle while the queue has room, set by the one-read one-write line stores.
// Border pixels produce no result; a result may wait in a four-entry queue while pixels flow.
// Reset (rst, synchronous, active high) empties the pipeline and the queue, zeroes the counters
// and the window, and loads threshold 16, width 640, height 480; line stores are not cleared.
module gray_neighbor_difference_edge_detect #(
  parameter int MAX_WIDTH = gnd_pkg::GND_MAX_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gnd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gnd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
  input  logic [23:0]                     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: edge_flag[0], out_row[12:1], out_col[23:13].
  output logic [23:0]                     m_axis_tdata,
  output logic                            m_axis_tlast
);
  import gnd_pkg::*;

  logic [THR_W-1:0]   threshold;
  dims_t              dims;
  logic               push;
  item_t              push_item;
  logic               pop;
  logic               head_valid;
  item_t              head;
  logic [LEVEL_W-1:0] level;
  logic               edge_flag;
  logic [DIM_W-1:0]   out_row;
  logic [OCOL_W-1:0]  out_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold         <= THRESHOLD_RESET;
      dims.image_width  <= WIDTH_RESET;
      dims.image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:    threshold         <= cfg_data[THR_W-1:0];
        CFG_IMAGE_WIDTH:  dims.image_width  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: dims.image_height <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gnd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .dims     (dims),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .red      (s_axis_tdata[7:0]),
    .green    (s_axis_tdata[15:8]),
    .blue     (s_axis_tdata[23:16]),
    .level    (level),
    .push     (push),
    .item     (push_item)
  );

  gnd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (level)
  );

  gnd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .threshold   (threshold),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .edge_flag   (edge_flag),
    .out_row     (out_row),
    .out_col     (out_col),
    .last_result (m_axis_tlast)
  );

  assign m_axis_tdata = {out_col, out_row, edge_flag};

endmodule

>>> rtl/core/gnd_checker.sv
`timescale 1ns / 1ps
`include "gray_neighbor_difference_edge_detect_assert.svh"
module gnd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A result waiting for the sink keeps its fields.
  `GND_ASSERT_NXT(hold_result, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Results are for interior rows only, never for the top row.
  `GND_ASSERT_IMP(interior_row, clk, rst, m_axis_tvalid, m_axis_tdata[12:1] != 12'd0)

  // After reset, a result must pass stage one and the queue before it can show.
  `GND_ASSERT_NXT_ALWAYS(quiet_after_reset, clk, rst, !m_axis_tvalid ##1 !m_axis_tvalid)

endmodule

bind gray_neighbor_difference_edge_detect gnd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
